/* rtl/rmsd_pkg.sv */
// Shared constants and types for the rolling mean and standard deviation block.
// No dependencies; every other file of the block imports this package.
package rmsd_pkg;

    localparam int PRICE_W = 24;

    typedef logic [PRICE_W-1:0] price_t;

endpackage

/* rtl/rmsd_if.sv */
// Valid/ready channel interfaces for price samples and statistics results.
// Depends on rmsd_pkg for the price width and type.
interface rmsd_price_if;
    import rmsd_pkg::*;

    logic   valid;
    logic   ready;
    price_t price;

    modport source (output valid, output price, input ready);
    modport sink (input valid, input price, output ready);
endinterface

interface rmsd_stats_if;
    import rmsd_pkg::*;

    logic   valid;
    logic   ready;
    logic   window_full;
    price_t mean;
    price_t sdev;

    modport source (output valid, output window_full, output mean,
                    output sdev, input ready);
    modport sink (input valid, input window_full, input mean,
                  input sdev, output ready);
endinterface

/* rtl/rolling_mean_stddev.sv */
// Rolling mean and population standard deviation over the last WINDOW price samples.
// Depends on rmsd_pkg and the channel interfaces in rmsd_if.sv.
//
// Usage: each transaction on the samples channel carries one UQ16.8 price. For every
// sample one transaction leaves on the stats channel. Until WINDOW samples have been
// taken, window_full is low and both statistics are zero; after that the block gives
// floor(S/N) and the floor square root of floor((N*Q - S*S)/(N*N)).
// Work on one sample runs through a shift-and-add multiplier that retires one
// multiplier bit per cycle, a restoring divider that produces one quotient bit per
// cycle and a square root unit that produces one root bit per cycle.
// While the window fills, a sample runs only through the update of the square sum (a
// multiply by |new - oldest|) and the completion state. With a full window it runs in
// turn through the square sum update, the products N*Q and S*S, the divider, the
// square root unit and the completion state.
// A new sample is taken only in the idle state; the finished result sits in an output
// register, so the next sample is accepted while the receiver stalls. A result that
// finds the output register still full waits until it is taken.
// Reset empties the window, clears the sums and the fill count and drops any result.
module rolling_mean_stddev #(
    parameter int WINDOW = 20
) (
    input  logic clk,
    input  logic rst_n,
    rmsd_price_if.sink   samples,
    rmsd_stats_if.source stats
);
    import rmsd_pkg::*;

    localparam int PW         = PRICE_W;
    localparam int CW         = $clog2(WINDOW + 1);
    localparam int SW         = PW + $clog2(WINDOW);
    localparam int QW         = 2 * PW + $clog2(WINDOW);
    localparam int AW         = 2 * SW;
    localparam int VW         = 2 * PW;
    localparam int D2         = WINDOW * WINDOW;
    localparam int DW         = $clog2(D2 + 1);
    localparam int KW         = $clog2(AW + 1);
    localparam int MEAN_START = AW - SW;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SQUARES = 7'b0000010,
        ST_NQ      = 7'b0000100,
        ST_SS      = 7'b0001000,
        ST_DIV     = 7'b0010000,
        ST_SQRT    = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [QW-1:0]   sq_reg, sq_next;
    logic            ovalid_reg, ovalid_next;

    price_t          win_reg [WINDOW];
    logic [AW-1:0]   acc_reg, acc_next;
    logic [AW-1:0]   mcand_reg, mcand_next;
    logic [SW-1:0]   mplier_reg, mplier_next;
    logic            sub_reg, sub_next;
    logic [KW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   mrem_reg, mrem_next;
    logic [SW-1:0]   mq_reg, mq_next;
    logic [PW:0]     srem_reg, srem_next;
    price_t          root_reg, root_next;
    logic            full_reg, full_next;
    logic            ofull_reg, ofull_next;
    price_t          omean_reg, omean_next;
    price_t          ostd_reg, ostd_next;

    logic            accept;
    price_t          oldest;
    logic signed [PW:0] diff;
    logic [PW:0]     pair_sum;
    logic [AW-1:0]   mul_acc;
    logic            mul_done;
    logic [DW:0]     rem_sh;
    logic            var_ge;
    logic [CW:0]     mrem_sh;
    logic            mean_ge;
    logic [PW+2:0]   srem_sh;
    logic [PW+2:0]   trial;
    logic            root_ge;

    assign accept   = samples.valid && samples.ready;
    assign oldest   = (fill_reg == CW'(WINDOW)) ? win_reg[WINDOW-1] : '0;
    assign diff     = $signed({1'b0, samples.price}) - $signed({1'b0, oldest});
    assign pair_sum = {1'b0, samples.price} + {1'b0, oldest};
    assign mul_acc  = sub_reg ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
    assign mul_done = (mplier_reg == '0);

    assign rem_sh   = {rem_reg, acc_reg[AW-1]};
    assign var_ge   = (rem_sh >= (DW+1)'(D2));
    assign mrem_sh  = {mrem_reg, mq_reg[SW-1]};
    assign mean_ge  = (mrem_sh >= (CW+1)'(WINDOW));
    assign srem_sh  = {srem_reg, acc_reg[VW-1 -: 2]};
    assign trial    = (PW+3)'({root_reg, 2'b01});
    assign root_ge  = (srem_sh >= trial);

    assign samples.ready     = (state_reg == ST_IDLE);
    assign stats.valid       = ovalid_reg;
    assign stats.window_full = ofull_reg;
    assign stats.mean        = omean_reg;
    assign stats.sdev        = ostd_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        sq_next     = sq_reg;
        ovalid_next = ovalid_reg && !stats.ready;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        sub_next    = sub_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        mrem_next   = mrem_reg;
        mq_next     = mq_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        full_next   = full_reg;
        ofull_next  = ofull_reg;
        omean_next  = omean_reg;
        ostd_next   = ostd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    // The square sum moves by new^2 - old^2 = (new - old) * (new + old).
                    sum_next    = sum_reg + $unsigned(SW'(diff));
                    acc_next    = AW'(sq_reg);
                    mcand_next  = AW'(pair_sum);
                    mplier_next = diff[PW] ? SW'(-diff) : SW'(diff);
                    sub_next    = diff[PW];
                    if (fill_reg != CW'(WINDOW))
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    state_next = ST_SQUARES;
                end
            end
            ST_SQUARES:
            begin
                if (mul_done)
                begin
                    sq_next = acc_reg[QW-1:0];
                    if (fill_reg == CW'(WINDOW))
                    begin
                        acc_next    = '0;
                        mcand_next  = AW'(acc_reg[QW-1:0]);
                        mplier_next = SW'(WINDOW);
                        sub_next    = 1'b0;
                        state_next  = ST_NQ;
                    end
                    else
                    begin
                        full_next  = 1'b0;
                        mq_next    = '0;
                        root_next  = '0;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = mul_acc;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_NQ:
            begin
                if (mul_done)
                begin
                    mcand_next  = AW'(sum_reg);
                    mplier_next = sum_reg;
                    sub_next    = 1'b1;
                    state_next  = ST_SS;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = mul_acc;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_SS:
            begin
                if (mul_done)
                begin
                    rem_next   = '0;
                    mrem_next  = '0;
                    mq_next    = sum_reg;
                    cnt_next   = KW'(AW);
                    state_next = ST_DIV;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = mul_acc;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_DIV:
            begin
                rem_next = var_ge ? DW'(rem_sh - (DW+1)'(D2)) : rem_sh[DW-1:0];
                acc_next = {acc_reg[AW-2:0], var_ge};
                // The mean quotient needs only the sum's width, so it runs in the first steps.
                if (cnt_reg > KW'(MEAN_START))
                begin
                    mrem_next = mean_ge ? CW'(mrem_sh - (CW+1)'(WINDOW)) : mrem_sh[CW-1:0];
                    mq_next   = {mq_reg[SW-2:0], mean_ge};
                end
                if (cnt_reg == KW'(1))
                begin
                    srem_next  = '0;
                    root_next  = '0;
                    full_next  = 1'b1;
                    cnt_next   = KW'(PW);
                    state_next = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg - KW'(1);
                end
            end
            ST_SQRT:
            begin
                srem_next = root_ge ? (PW+1)'(srem_sh - trial) : (PW+1)'(srem_sh);
                root_next = {root_reg[PW-2:0], root_ge};
                acc_next  = acc_reg << 2;
                if (cnt_reg == KW'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - KW'(1);
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || stats.ready)
                begin
                    ovalid_next = 1'b1;
                    ofull_next  = full_reg;
                    omean_next  = mq_reg[PW-1:0];
                    ostd_next   = root_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        sub_reg    <= sub_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        mrem_reg   <= mrem_next;
        mq_reg     <= mq_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        full_reg   <= full_next;
        ofull_reg  <= ofull_next;
        omean_reg  <= omean_next;
        ostd_reg   <= ostd_next;
        if (accept)
        begin
            win_reg[0] <= samples.price;
            for (int i = 1; i < WINDOW; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

`ifndef SYNTH
    // A result that raises stats.valid comes from the completion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stats.valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the completion state");

    // A result register that is still full is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        stats.valid && !stats.ready |=> $stable(stats.sdev) && $stable(stats.mean))
        else $error("stalled result was overwritten");

    // Without a full window the statistics are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        stats.valid && !stats.window_full |-> stats.mean == '0 && stats.sdev == '0)
        else $error("statistics reported before the window is full");

    // The fill count never passes the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW))
        else $error("fill count beyond the window length");

    // An accepted transaction always starts the square sum update.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SQUARES)
        else $error("accepted sample did not start processing");
`endif

endmodule
